@@ hdl/esd_pkg.sv @@
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and constants for the escape sequence decoder: decode phases,
// the queue entry passed from front to back, character codes and the
// named-escape lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_HEX  = 2'd2,
        PH_DEC  = 2'd3
    } esd_phase_t;

    // one accepted byte produces an optional escape result and an optional
    // plain result (plain char or end marker) taken from the same byte
    typedef struct packed {
        logic        has_first;
        logic [31:0] first_value;
        logic        first_ovf;
        logic        has_second;
        logic [7:0]  second_byte;
    } esd_entry_t;

    localparam logic [7:0]  CHAR_NUL   = 8'h00;
    localparam logic [7:0]  CHAR_BSL   = 8'h5C;
    localparam logic [7:0]  CHAR_X     = 8'h78;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;
    localparam logic [7:0]  CHAR_0     = 8'h30;
    localparam logic [7:0]  CHAR_9     = 8'h39;
    localparam logic [7:0]  CHAR_UA    = 8'h41;
    localparam logic [7:0]  CHAR_UF    = 8'h46;
    localparam logic [7:0]  CHAR_LA    = 8'h61;
    localparam logic [7:0]  CHAR_LF    = 8'h66;
    localparam logic [3:0]  HEX_LETTER_BIAS = 4'd9;
    localparam logic [30:0] MAG_MAX    = 31'h7FFF_FFFF;

    // value of a named escape, zero when the byte is not one
    function automatic logic [7:0] esc_value(input logic [7:0] b);
        logic [7:0] v;
        begin
            unique case (b)
                8'h6E:   v = 8'd10;  // n
                8'h72:   v = 8'd13;  // r
                8'h74:   v = 8'd9;   // t
                8'h76:   v = 8'd11;  // v
                8'h61:   v = 8'd7;   // a
                8'h62:   v = 8'd8;   // b
                8'h66:   v = 8'd12;  // f
                8'h27:   v = 8'd39;  // single quote
                8'h22:   v = 8'd34;  // double quote
                8'h5C:   v = 8'd92;  // backslash
                8'h3F:   v = 8'd63;  // question mark
                default: v = 8'd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/esd_front.sv @@
// ----------------------------------------------------------------------------
// esd_front
// Accepts source bytes, tracks the escape phase and numeric accumulator, and
// pushes one queue entry per byte that yields at least one result.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    input  wire [7:0]            byte_in,
    output logic                 in_stall,
    input  wire                  q_full,
    output logic                 push,
    output esd_pkg::esd_entry_t  entry
);
    import esd_pkg::*;

    esd_phase_t  phase_reg, phase_next;
    logic [30:0] acc_reg, acc_next;
    logic        hex_cnt_reg, hex_cnt_next;
    logic        neg_reg, neg_next;
    logic        sat_reg, sat_next;

    logic        accept;
    logic        is_dig, is_hexl, is_named, is_bsl;
    logic [7:0]  named_val;
    logic [3:0]  hex_val;
    logic [34:0] dec_prod;
    logic        dec_ovf;
    logic [30:0] hex_acc;
    logic [31:0] dec_value;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;

    assign is_dig    = (byte_in >= CHAR_0) && (byte_in <= CHAR_9);
    assign is_hexl   = is_dig || ((byte_in >= CHAR_UA) && (byte_in <= CHAR_UF))
                              || ((byte_in >= CHAR_LA) && (byte_in <= CHAR_LF));
    assign named_val = esc_value(byte_in);
    assign is_named  = (named_val != 8'd0);
    assign is_bsl    = (byte_in == CHAR_BSL);

    assign hex_val = is_dig ? byte_in[3:0] : ({1'b0, byte_in[2:0]} + HEX_LETTER_BIAS);
    assign hex_acc = {acc_reg[26:0], hex_val};

    // acc * 10 + digit as two shifts and two adds
    assign dec_prod = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                    + {31'd0, byte_in[3:0]};
    assign dec_ovf  = (dec_prod > {4'd0, MAG_MAX});

    assign dec_value = (neg_reg) ? (32'd0 - {1'b0, acc_reg}) : {1'b0, acc_reg};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_IDLE:
                    phase_next = is_bsl ? PH_ESC : PH_IDLE;
                PH_ESC:
                    priority if (is_named)                phase_next = PH_IDLE;
                    else if (byte_in == CHAR_X)           phase_next = PH_HEX;
                    else if (byte_in == CHAR_MINUS)       phase_next = PH_DEC;
                    else if (is_dig)                      phase_next = PH_DEC;
                    else                                  phase_next = PH_IDLE;
                PH_HEX:
                    if (is_hexl)
                        phase_next = hex_cnt_reg ? PH_IDLE : PH_HEX;
                    else
                        phase_next = is_bsl ? PH_ESC : PH_IDLE;
                PH_DEC:
                    if (is_dig)
                        phase_next = PH_DEC;
                    else
                        phase_next = is_bsl ? PH_ESC : PH_IDLE;
            endcase
        end
    end

    // results and datapath
    always_comb
    begin
        acc_next     = acc_reg;
        hex_cnt_next = hex_cnt_reg;
        neg_next     = neg_reg;
        sat_next     = sat_reg;
        entry        = '0;
        entry.second_byte = byte_in;
        if (accept)
        begin
            unique case (phase_reg)
                PH_IDLE:
                    entry.has_second = !is_bsl;
                PH_ESC:
                    priority if (is_named)
                    begin
                        entry.has_first   = 1'b1;
                        entry.first_value = {24'd0, named_val};
                    end
                    else if ((byte_in == CHAR_X) || (byte_in == CHAR_MINUS) || is_dig)
                    begin
                        acc_next     = is_dig ? {27'd0, byte_in[3:0]} : 31'd0;
                        hex_cnt_next = 1'b0;
                        neg_next     = (byte_in == CHAR_MINUS);
                        sat_next     = 1'b0;
                    end
                    else
                    begin
                        // bad escape gives 0, then the byte as a plain char
                        entry.has_first  = 1'b1;
                        entry.has_second = !is_bsl;
                    end
                PH_HEX:
                    if (is_hexl)
                    begin
                        acc_next     = hex_acc;
                        hex_cnt_next = 1'b1;
                        if (hex_cnt_reg)
                        begin
                            entry.has_first   = 1'b1;
                            entry.first_value = {1'b0, hex_acc};
                        end
                    end
                    else
                    begin
                        entry.has_first   = 1'b1;
                        entry.first_value = {1'b0, acc_reg};
                        entry.has_second  = !is_bsl;
                    end
                PH_DEC:
                    if (is_dig)
                    begin
                        acc_next = dec_ovf ? MAG_MAX : dec_prod[30:0];
                        sat_next = sat_reg || dec_ovf;
                    end
                    else
                    begin
                        entry.has_first   = 1'b1;
                        entry.first_value = dec_value;
                        entry.first_ovf   = sat_reg;
                        entry.has_second  = !is_bsl;
                    end
            endcase
        end
    end

    assign push = accept && (entry.has_first || entry.has_second);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            acc_reg     <= '0;
            hex_cnt_reg <= 1'b0;
            neg_reg     <= 1'b0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            hex_cnt_reg <= hex_cnt_next;
            neg_reg     <= neg_next;
            sat_reg     <= sat_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/esd_queue.sv @@
// ----------------------------------------------------------------------------
// esd_queue
// Small register FIFO of decoded entries between front and back.
// DEPTH must be a power of two, at least 2; the block itself does not check it.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_queue #(
    parameter int DEPTH = 4
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  esd_pkg::esd_entry_t  wr_data,
    input  wire                  pop,
    output esd_pkg::esd_entry_t  rd_data,
    output logic                 empty,
    output logic                 full
);
    import esd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

    esd_entry_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_DEPTH);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/esd_back.sv @@
// ----------------------------------------------------------------------------
// esd_back
// Drains queue entries and presents results through the output register,
// one per cycle unless stalled, holding an entry's second result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  esd_pkg::esd_entry_t  q_data,
    input  wire                  q_empty,
    output logic                 pop,
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic signed [31:0]   char_value,
    output logic                 is_end,
    output logic                 overflow,
    output logic                 last
);
    import esd_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] value_reg, value_next;
    logic        end_reg, end_next;
    logic        ovf_reg, ovf_next;
    logic        last_reg, last_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_byte_reg, pend_byte_next;
    logic        load;

    // output register free or being taken this cycle
    assign load = !out_valid_reg || !out_stall;
    assign pop  = load && !pend_valid_reg && !q_empty;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        value_next      = value_reg;
        end_next        = end_reg;
        ovf_next        = ovf_reg;
        last_next       = last_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        if (load)
        begin
            priority if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                value_next      = {24'd0, pend_byte_reg};
                end_next        = (pend_byte_reg == CHAR_NUL);
                ovf_next        = 1'b0;
                last_next       = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (!q_empty && q_data.has_first)
            begin
                out_valid_next  = 1'b1;
                value_next      = q_data.first_value;
                end_next        = 1'b0;
                ovf_next        = q_data.first_ovf;
                last_next       = !q_data.has_second;
                pend_valid_next = q_data.has_second;
                pend_byte_next  = q_data.second_byte;
            end
            else if (!q_empty)
            begin
                out_valid_next  = 1'b1;
                value_next      = {24'd0, q_data.second_byte};
                end_next        = (q_data.second_byte == CHAR_NUL);
                ovf_next        = 1'b0;
                last_next       = 1'b1;
            end
            else
            begin
                out_valid_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        end_reg       <= end_next;
        ovf_reg       <= ovf_next;
        last_reg      <= last_next;
        pend_byte_reg <= pend_byte_next;
    end

    assign out_valid  = out_valid_reg;
    assign char_value = $signed(value_reg);
    assign is_end     = end_reg;
    assign overflow   = ovf_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

@@ hdl/escape_sequence_decoder.sv @@
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Streaming decoder of C-style escaped character text: named escapes, \x with
// up to two hex digits, signed decimal escapes with saturation, end marker.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   byte_in
//   out      output     out_valid / out_stall char_value, is_end, overflow, last
//
// one byte is taken per cycle while the queue is not full; the first result
// of a request passes the queue and then the output register before it is shown
// a byte that closes a numeric or bad escape and is itself a character gives
// two results, which are presented on the output one after the other
// front stalls only when the QUEUE_DEPTH-entry queue is full
// reset is asynchronous and needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  [7:0]         byte_in,
    output logic               out_valid,
    input  wire                out_stall,
    output logic signed [31:0] char_value,
    output logic               is_end,
    output logic               overflow,
    output logic               last
);
    import esd_pkg::*;

    esd_entry_t push_data;
    esd_entry_t pop_data;
    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;

    esd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .byte_in  (byte_in),
        .in_stall (in_stall),
        .q_full   (q_full),
        .push     (q_push),
        .entry    (push_data)
    );

    esd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_data),
        .pop     (q_pop),
        .rd_data (pop_data),
        .empty   (q_empty),
        .full    (q_full)
    );

    esd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (pop_data),
        .q_empty    (q_empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_value (char_value),
        .is_end     (is_end),
        .overflow   (overflow),
        .last       (last)
    );

    // no push into a full queue
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    // no pop from an empty queue
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // end marker carries zero and no overflow
    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_end) |-> (char_value == 32'sd0 && !overflow && last))
        else $error("end marker with data");

    // a byte with nothing to emit never enters the queue
    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (push_data.has_first || push_data.has_second))
        else $error("empty entry pushed");

endmodule

`default_nettype wire
